@@ rtl/core/utp_pkg.sv @@
package utp_pkg;

  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_PASS      = 2'd1;
  localparam logic [1:0] MODE_UTF16     = 2'd2;

  localparam logic [15:0] MAX_SHOWN_RESET = 16'd2048;

  localparam logic [7:0] BOM_LO = 8'hFF;
  localparam logic [7:0] BOM_HI = 8'hFE;

  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_DOT   = 8'h2E;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One decoded input beat: zero to three text bytes plus end-of-file info.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            last;
    logic            truncated;
    logic [15:0]     shown;
    logic [31:0]     total;
  } utp_cmd_t;

  function automatic logic [7:0] sanitize(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CHR_CR) begin
      r = CHR_SPACE;
    end else if (b < CHR_SPACE && b != CHR_LF && b != CHR_TAB) begin
      r = CHR_DOT;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/utp_front.sv @@
module utp_front import utp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_file,
  input  logic        fifo_full,
  output logic        push,
  output utp_cmd_t    cmd
);

  logic [15:0] max_shown;
  logic [1:0]  mode, mode_next;
  logic [7:0]  held, held_next;
  logic [31:0] position, position_next;
  logic        saw_first, saw_first_next;

  logic        accept;
  logic [31:0] pos_inc;
  logic        in_limit;
  logic        limit_nz;
  logic [15:0] unit;
  logic        over;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign pos_inc  = (position == 32'hFFFF_FFFF) ? position : position + 32'd1;
  assign in_limit = position < {16'd0, max_shown};
  assign limit_nz = max_shown != 16'd0;
  assign unit     = {in_byte, held};
  assign over     = pos_inc > {16'd0, max_shown};

  always_comb begin
    cmd            = '0;
    mode_next      = mode;
    held_next      = held;
    saw_first_next = saw_first;
    case (mode)
      MODE_UNDECIDED: begin
        if (!saw_first) begin
          if (in_byte == BOM_LO) begin
            saw_first_next = 1'b1;
            held_next      = in_byte;
          end else begin
            mode_next = MODE_PASS;
            if (in_limit) begin
              cmd.data[0] = in_byte;
              cmd.count   = 2'd1;
            end
          end
        end else begin
          saw_first_next = 1'b0;
          if (in_byte == BOM_HI) begin
            mode_next = MODE_UTF16;
          end else begin
            mode_next = MODE_PASS;
            if (limit_nz && in_limit) begin
              cmd.data[0] = held;
              cmd.data[1] = in_byte;
              cmd.count   = 2'd2;
            end else if (limit_nz) begin
              cmd.data[0] = held;
              cmd.count   = 2'd1;
            end else if (in_limit) begin
              cmd.data[0] = in_byte;
              cmd.count   = 2'd1;
            end
          end
        end
      end
      MODE_PASS: begin
        if (in_limit) begin
          cmd.data[0] = in_byte;
          cmd.count   = 2'd1;
        end
      end
      MODE_UTF16: begin
        if (in_limit) begin
          if (position[0]) begin
            if (unit[15:11] == 5'b11011) begin
              cmd.count = 2'd0;  // surrogate half: dropped
            end else if (unit < 16'h0080) begin
              cmd.data[0] = unit[7:0];
              cmd.count   = 2'd1;
            end else if (unit < 16'h0800) begin
              cmd.data[0] = {3'b110, unit[10:6]};
              cmd.data[1] = {2'b10, unit[5:0]};
              cmd.count   = 2'd2;
            end else begin
              cmd.data[0] = {4'b1110, unit[15:12]};
              cmd.data[1] = {2'b10, unit[11:6]};
              cmd.data[2] = {2'b10, unit[5:0]};
              cmd.count   = 2'd3;
            end
          end else begin
            held_next = in_byte;
          end
        end
      end
      default: begin
        cmd.count = 2'd0;
      end
    endcase

    position_next = pos_inc;
    if (end_of_file) begin
      // file ended on a lone leading FF: show it as plain text
      if (mode_next == MODE_UNDECIDED && saw_first_next && limit_nz) begin
        cmd.data[0] = held_next;
        cmd.count   = 2'd1;
      end
      cmd.last      = 1'b1;
      cmd.truncated = over;
      cmd.shown     = over ? max_shown : pos_inc[15:0];
      cmd.total     = pos_inc;
      mode_next      = MODE_UNDECIDED;
      held_next      = '0;
      saw_first_next = 1'b0;
      position_next  = '0;
    end
  end

  assign push = accept && (cmd.count != 2'd0 || end_of_file);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_shown <= MAX_SHOWN_RESET;
    end else if (cfg_wr_en) begin
      max_shown <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_UNDECIDED;
      held      <= '0;
      position  <= '0;
      saw_first <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      held      <= held_next;
      position  <= position_next;
      saw_first <= saw_first_next;
    end
  end

endmodule

@@ rtl/core/utp_fifo.sv @@
module utp_fifo import utp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  utp_cmd_t wr_data,
  input  logic     pop,
  output utp_cmd_t rd_data,
  output logic     full,
  output logic     empty
);

  utp_cmd_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full    = count == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full fifo");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty fifo");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("fifo count did not advance on push");

endmodule

@@ rtl/core/utp_back.sv @@
module utp_back import utp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  utp_cmd_t    head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        is_last,
  output logic        truncated,
  output logic [15:0] shown_count,
  output logic [31:0] total_count
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       at_last;
  logic       load;
  logic       fire;
  logic       has_byte;

  assign has_byte = head.count != 2'd0;
  assign last_idx = has_byte ? head.count - 2'd1 : 2'd0;
  assign at_last  = idx == last_idx;
  assign load     = !out_valid || !out_stall;
  assign fire     = load && !empty;
  assign pop      = fire && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (fire) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= has_byte ? sanitize(head.data[idx]) : 8'd0;
      byte_valid  <= has_byte;
      is_last     <= head.last && at_last;
      truncated   <= (head.last && at_last) ? head.truncated : 1'b0;
      shown_count <= (head.last && at_last) ? head.shown : 16'd0;
      total_count <= (head.last && at_last) ? head.total : 32'd0;
    end
  end

endmodule

@@ rtl/core/utf16le_text_preview_transcoder_top.sv @@
// Text preview transcoder: raw file bytes in, sanitized UTF-8 text bytes out.
//
// Input channel (in_valid / in_stall): one file byte per beat, end_of_file
// set on the final byte. A file opening with FF FE is decoded as UTF-16LE
// (surrogates dropped, odd tail byte dropped); anything else passes through.
// Only the first max_shown bytes produce text. The user must write max_shown
// (cfg_wr_en / cfg_wr_data, reset value 2048) only while idle; not enforced.
//
// Output channel (out_valid / out_stall): one result beat per text byte. The
// final beat of a file carries is_last with shown/total counts; when the last
// input byte yields no text, an extra beat with byte_valid low carries them.
//
// Each command is queued, then registered at the output. The front end
// decodes one byte per cycle into a 4-entry command queue while it is not
// full; the back end drains one result per cycle while out_stall is low, so
// a UTF-16 pair expanding to three bytes costs three output beats.
// Unstalled, plain text sustains one byte per cycle. When the receiver
// stalls, the output register holds, the queue fills, and in_stall rises
// once it is full. Reset empties the queue, drops the output beat and
// returns the decoder to the start of a file.
module utf16le_text_preview_transcoder_top import utp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        is_last,
  output logic        truncated,
  output logic [15:0] shown_count,
  output logic [31:0] total_count
);

  utp_cmd_t wr_cmd;
  utp_cmd_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  // decode / classify one byte per beat
  utp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .fifo_full   (full),
    .push        (push),
    .cmd         (wr_cmd)
  );

  // command queue decouples decode from output pacing
  utp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_cmd),
    .pop     (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  // serialize each command into result beats
  utp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .is_last     (is_last),
    .truncated   (truncated),
    .shown_count (shown_count),
    .total_count (total_count)
  );

endmodule
